FILE: rtl/core/tcs_pkg.sv
// Shared types, constants and helper functions of the text console scrollback engine.
package tcs_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int LINES    = 512;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int SLOT_W = $clog2(LINES);
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int DEPTH  = LINES * MAX_COLS;
  localparam int CELL_W = 16;

  localparam logic [7:0] RST_COLS = 8'd80;
  localparam logic [6:0] RST_ROWS = 7'd25;
  localparam logic [7:0] RST_ATTR = 8'h0F;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_ATTR    = 2'd2;

  typedef enum logic [2:0] {
    CMD_CHAR   = 3'd0,
    CMD_PGUP   = 3'd1,
    CMD_PGDN   = 3'd2,
    CMD_BOTTOM = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_CBACK  = 3'd5,
    CMD_GOTO   = 3'd6,
    CMD_READ   = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    OP_PRINT  = 4'd0,
    OP_BS     = 4'd1,
    OP_NL     = 4'd2,
    OP_CR     = 4'd3,
    OP_PGUP   = 4'd4,
    OP_PGDN   = 4'd5,
    OP_BOTTOM = 4'd6,
    OP_CLEAR  = 4'd7,
    OP_CBACK  = 4'd8,
    OP_GOTO   = 4'd9,
    OP_READ   = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    RET_WRITE = 2'd0,
    RET_NL    = 2'd1,
    RET_DONE  = 2'd2
  } ret_t;

  typedef enum logic [1:0] {
    BK_GROW  = 2'd0,
    BK_CLEAR = 2'd1,
    BK_INIT  = 2'd2
  } bkind_t;

  // effective configuration, already clamped
  typedef struct packed {
    logic [7:0] cols;
    logic [6:0] rws;
    logic [7:0] attr;
  } cfg_t;

  // classified command as it travels through the queue
  typedef struct packed {
    op_t        op;
    logic       pin;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [COL_W-1:0] col;
    logic [5:0] row;
  } qcmd_t;

  function automatic logic [7:0] eff_cols(logic [7:0] c);
    if (c == 8'd0) return 8'd1;
    if (c > 8'(MAX_COLS)) return 8'(MAX_COLS);
    return c;
  endfunction

  function automatic logic [6:0] eff_rows(logic [6:0] r);
    if (r == 7'd0) return 7'd1;
    if (r > 7'(MAX_ROWS)) return 7'(MAX_ROWS);
    return r;
  endfunction

  function automatic logic [9:0] max_top(logic [9:0] held, logic [6:0] r);
    if (held > {3'b000, r}) return held - {3'b000, r};
    return 10'd0;
  endfunction

endpackage

FILE: rtl/core/tcs_if.sv
// Input and result channel interfaces of the text console scrollback engine.
interface tcs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] char_code;
  logic       use_own_attribute;
  logic [7:0] item_attribute;
  logic [7:0] target_column;
  logic [7:0] target_row;

  modport source (output valid, command, char_code, use_own_attribute, item_attribute,
                  target_column, target_row, input ready);
  modport sink (input valid, command, char_code, use_own_attribute, item_attribute,
                target_column, target_row, output ready);
endinterface

interface tcs_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_column;
  logic [5:0]  cursor_row;
  logic [8:0]  view_top_line;
  logic [9:0]  line_count;
  logic        following;
  logic [12:0] hw_cursor_position;
  logic [15:0] cell_value;

  modport source (output valid, cursor_column, cursor_row, view_top_line, line_count,
                  following, hw_cursor_position, cell_value, input ready);
  modport sink (input valid, cursor_column, cursor_row, view_top_line, line_count,
                following, hw_cursor_position, cell_value, output ready);
endinterface

FILE: rtl/core/tcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tcs_front.sv
// Front end: accept words, classify them and hold them in a two-entry queue.
module tcs_front (
  input  logic           clk,
  input  logic           rst_n,
  tcs_in_if.sink         in_ch,
  input  tcs_pkg::cfg_t  cfg,
  output tcs_pkg::qcmd_t q_cmd,
  output logic           q_valid,
  input  logic           q_pop
);

  tcs_pkg::qcmd_t slot_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r;
  tcs_pkg::qcmd_t dec;
  logic           push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_cmd       = slot_r[rptr_r];

  always_comb begin
    dec.op   = tcs_pkg::OP_PRINT;
    dec.pin  = 1'b1;
    dec.ch   = in_ch.char_code;
    dec.attr = in_ch.use_own_attribute ? in_ch.item_attribute : cfg.attr;
    dec.col  = (in_ch.target_column < cfg.cols) ? in_ch.target_column[tcs_pkg::COL_W-1:0]
                                                : tcs_pkg::COL_W'(cfg.cols - 8'd1);
    dec.row  = ({1'b0, in_ch.target_row} < {2'b00, cfg.rws}) ? in_ch.target_row[5:0]
                                                             : 6'(cfg.rws - 7'd1);
    case (tcs_pkg::cmd_t'(in_ch.command))
      tcs_pkg::CMD_CHAR: begin
        if (in_ch.char_code == tcs_pkg::CH_BS) begin
          dec.op  = tcs_pkg::OP_BS;
          dec.pin = in_ch.use_own_attribute;
        end else if (in_ch.char_code == tcs_pkg::CH_LF) begin
          dec.op = tcs_pkg::OP_NL;
        end else if (in_ch.char_code == tcs_pkg::CH_CR) begin
          dec.op = tcs_pkg::OP_CR;
        end else begin
          dec.op = tcs_pkg::OP_PRINT;
        end
      end
      tcs_pkg::CMD_PGUP:   dec.op = tcs_pkg::OP_PGUP;
      tcs_pkg::CMD_PGDN:   dec.op = tcs_pkg::OP_PGDN;
      tcs_pkg::CMD_BOTTOM: dec.op = tcs_pkg::OP_BOTTOM;
      tcs_pkg::CMD_CLEAR:  dec.op = tcs_pkg::OP_CLEAR;
      tcs_pkg::CMD_CBACK:  dec.op = tcs_pkg::OP_CBACK;
      tcs_pkg::CMD_GOTO:   dec.op = tcs_pkg::OP_GOTO;
      default:             dec.op = tcs_pkg::OP_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: rtl/core/tcs_back.sv
// Back end: sequencer that executes queued commands against the cell store.
module tcs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcs_pkg::cfg_t               cfg,
  input  tcs_pkg::qcmd_t              q_cmd,
  input  logic                        q_valid,
  output logic                        q_pop,
  output logic                        ram_we,
  output logic [tcs_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [tcs_pkg::CELL_W-1:0]  ram_wdata,
  output logic [tcs_pkg::ADDR_W-1:0]  ram_raddr,
  input  logic [tcs_pkg::CELL_W-1:0]  ram_rdata,
  tcs_out_if.source                   out_ch
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ENS   = 5'b00010,
    S_BLANK = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam int CW = tcs_pkg::COL_W;
  localparam int SW = tcs_pkg::SLOT_W;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    vt_r, vt_nxt, base_r, base_nxt, slot_r, slot_nxt;
  logic [9:0]       held_r, held_nxt, tgt_r, tgt_nxt;
  logic             follow_r, follow_nxt, wadv_r, wadv_nxt;
  logic [CW-1:0]    col_r, col_nxt, x_r, x_nxt, blast_r, blast_nxt;
  logic [5:0]       row_r, row_nxt;
  logic [7:0]       battr_r, battr_nxt, cattr_r, cattr_nxt;
  logic [15:0]      wcell_r, wcell_nxt, cell_r, cell_nxt;
  tcs_pkg::ret_t    ret_r, ret_nxt;
  tcs_pkg::bkind_t  bkind_r, bkind_nxt;

  logic             oval_r, load;
  logic [12:0]      hw;
  logic [9:0]       mt, line, sum10;
  logic [SW-1:0]    vt_e, vt1, b1;
  logic [9:0]       h1;
  logic             drop;
  logic [7:0]       c1;
  logic [CW-1:0]    cm1;
  logic [5:0]       rm1;

  assign cm1 = CW'(cfg.cols - 8'd1);
  assign rm1 = 6'(cfg.rws - 7'd1);
  assign mt  = tcs_pkg::max_top(held_r, cfg.rws);
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign load  = (state_r == S_DONE) && (!oval_r || out_ch.ready);

  always_comb begin
    state_nxt  = state_r;
    vt_nxt     = vt_r;
    base_nxt   = base_r;
    slot_nxt   = slot_r;
    held_nxt   = held_r;
    tgt_nxt    = tgt_r;
    follow_nxt = follow_r;
    wadv_nxt   = wadv_r;
    col_nxt    = col_r;
    x_nxt      = x_r;
    blast_nxt  = blast_r;
    row_nxt    = row_r;
    battr_nxt  = battr_r;
    cattr_nxt  = cattr_r;
    wcell_nxt  = wcell_r;
    cell_nxt   = cell_r;
    ret_nxt    = ret_r;
    bkind_nxt  = bkind_r;
    ram_we     = 1'b0;
    ram_waddr  = {slot_r, x_r};
    ram_wdata  = {battr_r, tcs_pkg::CH_SPACE};
    ram_raddr  = '0;
    vt_e       = vt_r;
    vt1        = vt_r;
    b1         = base_r;
    h1         = held_r;
    drop       = 1'b0;
    c1         = {1'b0, col_r} + 8'd1;
    line       = '0;
    sum10      = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cell_nxt = '0;
          state_nxt = S_DONE;
          // return the view to the bottom for character work that asks for it
          if (q_cmd.pin && !follow_r) begin
            vt_e = mt[SW-1:0];
          end
          case (q_cmd.op)
            tcs_pkg::OP_PRINT, tcs_pkg::OP_BS, tcs_pkg::OP_NL, tcs_pkg::OP_CR: begin
              vt_nxt = vt_e;
              if (q_cmd.pin) begin
                follow_nxt = 1'b1;
              end
              battr_nxt = cfg.attr;
              tgt_nxt   = {1'b0, vt_e} + {4'b0, row_r};
              ret_nxt   = tcs_pkg::RET_WRITE;
              if (q_cmd.op == tcs_pkg::OP_PRINT) begin
                battr_nxt = q_cmd.attr;
                cattr_nxt = q_cmd.attr;
                wcell_nxt = {q_cmd.attr, q_cmd.ch};
                wadv_nxt  = 1'b1;
                state_nxt = S_ENS;
              end else if (q_cmd.op == tcs_pkg::OP_BS) begin
                if (col_r != '0) begin
                  col_nxt   = col_r - 1'b1;
                  wcell_nxt = {cfg.attr, tcs_pkg::CH_SPACE};
                  wadv_nxt  = 1'b0;
                  state_nxt = S_ENS;
                end
              end else if (q_cmd.op == tcs_pkg::OP_NL) begin
                col_nxt   = '0;
                tgt_nxt   = {1'b0, vt_e} + {4'b0, row_r} + 10'd1;
                ret_nxt   = tcs_pkg::RET_NL;
                state_nxt = S_ENS;
              end else begin
                col_nxt = '0;
              end
            end
            tcs_pkg::OP_PGUP: begin
              follow_nxt = 1'b0;
              vt1 = ({1'b0, vt_r} > {3'b0, cfg.rws}) ? SW'({1'b0, vt_r} - {3'b0, cfg.rws})
                                                     : '0;
              vt_nxt = ({1'b0, vt1} > mt) ? mt[SW-1:0] : vt1;
            end
            tcs_pkg::OP_PGDN: begin
              sum10 = {1'b0, vt_r} + {3'b0, cfg.rws};
              if (sum10 >= mt) begin
                vt_nxt     = mt[SW-1:0];
                follow_nxt = 1'b1;
              end else begin
                vt_nxt = sum10[SW-1:0];
              end
            end
            tcs_pkg::OP_BOTTOM: begin
              follow_nxt = 1'b1;
              vt_nxt     = mt[SW-1:0];
            end
            tcs_pkg::OP_CLEAR: begin
              held_nxt   = 10'd1;
              vt_nxt     = '0;
              follow_nxt = 1'b1;
              col_nxt    = '0;
              row_nxt    = '0;
              slot_nxt   = base_r;
              x_nxt      = '0;
              blast_nxt  = cm1;
              battr_nxt  = cfg.attr;
              bkind_nxt  = tcs_pkg::BK_CLEAR;
              state_nxt  = S_BLANK;
            end
            tcs_pkg::OP_CBACK: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end else if (row_r != '0) begin
                row_nxt = row_r - 6'd1;
                col_nxt = cm1;
              end
            end
            tcs_pkg::OP_GOTO: begin
              col_nxt = q_cmd.col;
              row_nxt = q_cmd.row;
            end
            default: begin
              line = {1'b0, vt_r} + {4'b0, q_cmd.row};
              ram_raddr = {base_r + line[SW-1:0], q_cmd.col};
              if (line < held_r) begin
                state_nxt = S_READ;
              end else begin
                cell_nxt = {cfg.attr, tcs_pkg::CH_SPACE};
              end
            end
          endcase
        end
      end

      S_ENS: begin
        if (held_r <= tgt_r) begin
          // add one line; drop the oldest first when the ring is full
          drop = (held_r == 10'(tcs_pkg::LINES));
          if (drop) begin
            b1       = base_r + 1'b1;
            h1       = held_r - 10'd1;
            tgt_nxt  = tgt_r - 10'd1;
            vt_nxt   = (vt_r != '0) ? vt_r - 1'b1 : vt_r;
            base_nxt = b1;
            held_nxt = h1;
          end
          slot_nxt  = b1 + h1[SW-1:0];
          x_nxt     = '0;
          blast_nxt = cm1;
          bkind_nxt = tcs_pkg::BK_GROW;
          state_nxt = S_BLANK;
        end else begin
          case (ret_r)
            tcs_pkg::RET_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = {base_r + tgt_r[SW-1:0], col_r};
              ram_wdata = wcell_r;
              state_nxt = S_DONE;
              if (wadv_r) begin
                if (c1 >= cfg.cols) begin
                  col_nxt   = '0;
                  tgt_nxt   = {1'b0, vt_r} + {4'b0, row_r} + 10'd1;
                  state_nxt = S_ENS;
                  if ({1'b0, row_r} + 7'd1 >= cfg.rws) begin
                    battr_nxt = cfg.attr;
                    ret_nxt   = tcs_pkg::RET_NL;
                  end else begin
                    row_nxt   = row_r + 6'd1;
                    battr_nxt = cattr_r;
                    ret_nxt   = tcs_pkg::RET_DONE;
                  end
                end else begin
                  col_nxt = c1[CW-1:0];
                end
              end
            end
            tcs_pkg::RET_NL: begin
              sum10 = {1'b0, vt_r} + {3'b0, cfg.rws};
              if (tgt_r >= sum10) begin
                row_nxt = rm1;
                if (follow_r) begin
                  vt_nxt = mt[SW-1:0];
                end
              end else begin
                row_nxt = row_r + 6'd1;
              end
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_BLANK: begin
        ram_we = 1'b1;
        if (x_r == blast_r) begin
          case (bkind_r)
            tcs_pkg::BK_GROW: begin
              held_nxt  = held_r + 10'd1;
              state_nxt = S_ENS;
            end
            tcs_pkg::BK_CLEAR: state_nxt = S_DONE;
            default:           state_nxt = S_IDLE;
          endcase
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end

      S_READ: begin
        cell_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (follow_r) begin
      hw = 13'({7'b0, row_r} * {5'b0, cfg.cols}) + 13'(col_r);
    end else begin
      hw = 13'(cfg.cols * cfg.rws - 15'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // blank line 0 with the reset width and attribute
      state_r  <= S_BLANK;
      vt_r     <= '0;
      base_r   <= '0;
      slot_r   <= '0;
      held_r   <= 10'd1;
      follow_r <= 1'b1;
      col_r    <= '0;
      row_r    <= '0;
      x_r      <= '0;
      blast_r  <= CW'(tcs_pkg::RST_COLS - 8'd1);
      battr_r  <= tcs_pkg::RST_ATTR;
      bkind_r  <= tcs_pkg::BK_INIT;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vt_r     <= vt_nxt;
      base_r   <= base_nxt;
      slot_r   <= slot_nxt;
      held_r   <= held_nxt;
      follow_r <= follow_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      x_r      <= x_nxt;
      blast_r  <= blast_nxt;
      battr_r  <= battr_nxt;
      bkind_r  <= bkind_nxt;
      if (load) begin
        oval_r <= 1'b1;
      end else if (out_ch.ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_r   <= tgt_nxt;
    wadv_r  <= wadv_nxt;
    cattr_r <= cattr_nxt;
    wcell_r <= wcell_nxt;
    cell_r  <= cell_nxt;
    ret_r   <= ret_nxt;
    if (load) begin
      out_ch.cursor_column      <= col_r;
      out_ch.cursor_row         <= row_r;
      out_ch.view_top_line      <= vt_r;
      out_ch.line_count         <= held_r;
      out_ch.following          <= follow_r;
      out_ch.hw_cursor_position <= hw;
      out_ch.cell_value         <= cell_r;
    end
  end

  assign out_ch.valid = oval_r;

endmodule

FILE: rtl/core/text_console_scrollback_engine_core.sv
// Top level of the text console scrollback engine: config registers, front, back, store.
// A simple command passes the IDLE and DONE states before the result register;
//   a cell read adds READ; a newline, erasing backspace or printable adds ENS; a
//   wrap adds an ENS pass, each added line a BLANK pass. The back-end sequencer
//   takes a new word only when idle and has a single store write port; a clear
//   blanks a line column by column. Reset: synchronous active-low; afterwards
//   line 0 is blanked while the front queue already takes up to two words.
module text_console_scrollback_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  tcs_in_if.sink     in_ch,
  tcs_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  // raw configuration registers, clamped on the way out
  logic [7:0] cols_r;
  logic [6:0] rows_r;
  logic [7:0] attr_r;

  tcs_pkg::cfg_t  cfg;
  tcs_pkg::qcmd_t q_cmd;
  logic           q_valid, q_pop;

  logic                        ram_we;
  logic [tcs_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [tcs_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

  // take register writes; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= tcs_pkg::RST_COLS;
      rows_r <= tcs_pkg::RST_ROWS;
      attr_r <= tcs_pkg::RST_ATTR;
    end else if (cfg_we) begin
      case (cfg_index)
        tcs_pkg::REG_COLUMNS: cols_r <= cfg_wdata;
        tcs_pkg::REG_ROWS:    rows_r <= cfg_wdata[6:0];
        tcs_pkg::REG_ATTR:    attr_r <= cfg_wdata;
        default:              ;
      endcase
    end
  end

  assign cfg.cols = tcs_pkg::eff_cols(cols_r);
  assign cfg.rws  = tcs_pkg::eff_rows(rows_r);
  assign cfg.attr = attr_r;

  // front: classify and queue words
  tcs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // back: run commands, grow and blank lines, hold the result word
  tcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_cmd     (q_cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_ch    (out_ch)
  );

  // ring of lines: slot in the high bits, column in the low bits
  tcs_ram #(
    .WIDTH (tcs_pkg::CELL_W),
    .DEPTH (tcs_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: rtl/core/tcs_checker.sv
// Port-level checker of the text console scrollback engine and its bind.
module tcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] view_top_line,
  input logic [9:0] line_count
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_count) && $stable(view_top_line))
    else $error("stalled result word changed");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> line_count != 10'd0 && line_count <= 10'd512)
    else $error("line count out of range");

  a_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, view_top_line} < line_count)
    else $error("view top beyond held lines");

endmodule

bind text_console_scrollback_engine_core tcs_checker u_tcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .view_top_line (out_ch.view_top_line),
  .line_count    (out_ch.line_count)
);
